// ===== rtl/hcte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code table engine package
// Shared widths, command and status codes, FSM states and storage records.
// ----------------------------------------------------------------------------
package hcte_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int SYM_W        = 8;
  localparam int COUNT_W      = 24;
  localparam int WEIGHT_W     = 32;
  localparam int NODE_W       = 9;
  localparam int NODE_DEPTH   = 2 * NUM_SYMBOLS - 1;
  localparam int CODE_W       = 48;
  localparam int LEN_W        = 6;
  localparam int DEPTH_W      = 8;
  localparam int LEAF_W       = 9;
  localparam int LINK_W       = 2 * NODE_W;

  localparam logic [DEPTH_W-1:0] MAX_CODE_LEN   = DEPTH_W'(48);
  localparam logic [SYM_W-1:0]   INTERNAL_LABEL = SYM_W'(36);
  // Flipping the sign bit turns a signed label into an unsigned sort key.
  localparam logic [SYM_W-1:0]   LABEL_BIAS     = 8'h80;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_DECODE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_TREE  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COLLECT,
    S_SCAN,
    S_MERGE1,
    S_MERGE2,
    S_ROOT,
    S_ASSIGN_RD,
    S_ASSIGN_WL,
    S_ASSIGN_WR,
    S_LEAF,
    S_QUERY,
    S_DEC1,
    S_DEC2
  } state_t;

  // Ready-list entry, ordered as one unsigned word: weight, label, node index.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SYM_W-1:0]    label;
    logic [NODE_W-1:0]   node;
  } key_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [CODE_W-1:0]  code;
  } dc_t;

  typedef struct packed {
    logic              present;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } code_entry_t;

  typedef struct packed {
    logic               en;
    logic [SYM_W-1:0]   addr;
    logic [COUNT_W-1:0] data;
  } cnt_wr_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    code_entry_t      data;
  } code_wr_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              present;
    logic [SYM_W-1:0]  dsym;
    logic              dvalid;
    logic [LEAF_W-1:0] leaves;
  } res_t;

  function automatic logic key_less(input key_t a, input key_t b);
    logic [$bits(key_t)-1:0] va;
    logic [$bits(key_t)-1:0] vb;
    va = a;
    vb = b;
    return va < vb;
  endfunction

endpackage

// ===== rtl/hcte_count_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol count store
// 256-entry count memory; per-entry valid bits make unwritten entries read 0.
// ----------------------------------------------------------------------------
module hcte_count_store import hcte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cnt_wr_t            wr,
  input  logic [SYM_W-1:0]   rd_addr,
  output logic [COUNT_W-1:0] rd_data
);

  logic [COUNT_W-1:0]     mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// ===== rtl/hcte_code_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code table store
// 256-entry memory of present flag, code length and code per symbol.
// ----------------------------------------------------------------------------
module hcte_code_store import hcte_pkg::*; (
  input  logic             clk,
  input  code_wr_t         wr,
  input  logic [SYM_W-1:0] rd_addr,
  output code_entry_t      rd_data
);

  code_entry_t mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/huffman_code_table_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code table engine
// Builds a Huffman code over 256 byte symbols, answers code queries and
// decodes one bit at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown for one cycle with result_valid high; the
// receiver takes it unconditionally.
// Per command:
//   load: busy stays low, so a load can follow every cycle.
//   query: one code table read. decode: one node read, plus one more when
//   the bit lands on a leaf. Query or decode with no built tree answers
//   straight from idle.
//   build: each merge scans the ready-list memory once, one entry a cycle,
//   to find the two lowest of its n ready nodes, then moves the last ready
//   entry into a freed slot when it was neither of the two.
// Reset clears the counts (valid bits), the built flag and the walk position.
// A load invalidates the built tree until the next build.
// ----------------------------------------------------------------------------
module huffman_code_table_engine_unit import hcte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [COUNT_W-1:0] frequency,
  input  logic               code_bit,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [CODE_W-1:0]  code_value,
  output logic [LEN_W-1:0]   code_length,
  output logic               symbol_present,
  output logic [SYM_W-1:0]   decoded_symbol,
  output logic               decoded_valid,
  output logic [LEAF_W-1:0]  leaf_count
);

  state_t state, state_next;

  logic              tree_built;
  logic [NODE_W-1:0] walk;
  logic [NODE_W-1:0] root;
  logic [LEAF_W-1:0] leaves;
  logic [NODE_W-1:0] nodes;
  logic [LEAF_W-1:0] nready;
  logic [NODE_W-1:0] idx;
  logic              pend;
  logic [SYM_W-1:0]  pend_pos;
  logic              bit_r;
  key_t              best1, best2, last_key;
  logic [SYM_W-1:0]  pos1, pos2;
  logic              have1, have2;
  logic [NODE_W-1:0] a_r;
  logic [DEPTH_W-1:0] a_d;
  logic [CODE_W-1:0] a_code;
  logic              err;

  logic [LINK_W-1:0] node_mem [NODE_DEPTH];
  dc_t               dc_mem   [NODE_DEPTH];
  key_t              rdy_mem  [NUM_SYMBOLS];
  logic [LINK_W-1:0] node_q;
  dc_t               dc_q;
  key_t              rdy_q;

  logic              node_we;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  logic [LINK_W-1:0] node_wdata;
  logic              dc_we;
  logic [NODE_W-1:0] dc_waddr;
  dc_t               dc_wdata;
  logic              rdy_we;
  logic [SYM_W-1:0]  rdy_waddr;
  key_t              rdy_wdata;

  cnt_wr_t            cnt_wr;
  logic [COUNT_W-1:0] cnt_q;
  code_wr_t           code_wr;
  code_entry_t        code_q;
  res_t               res;

  logic              accept;
  cmd_t              cmd;
  logic [NODE_W-1:0] child;
  logic [SYM_W-1:0]  last_pos;
  logic              merge2;
  logic              scan_more, leaf_more;
  key_t              new_key;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cmd       = cmd_t'(command);
  assign child     = bit_r ? node_q[NODE_W-1:0] : node_q[LINK_W-1:NODE_W];
  assign last_pos  = SYM_W'(nready - LEAF_W'(1));
  assign merge2    = (last_pos != pos1) && (last_pos != pos2);
  assign scan_more = (LEAF_W'(idx) < nready);
  assign leaf_more = (LEAF_W'(idx) < leaves);
  assign new_key   = '{weight: best1.weight + best2.weight,
                       label:  INTERNAL_LABEL ^ LABEL_BIAS,
                       node:   nodes};

  hcte_count_store u_count (
    .clk     (clk),
    .rst     (rst),
    .wr      (cnt_wr),
    .rd_addr (idx[SYM_W-1:0]),
    .rd_data (cnt_q)
  );

  hcte_code_store u_code (
    .clk     (clk),
    .wr      (code_wr),
    .rd_addr (symbol),
    .rd_data (code_q)
  );

  // Node, depth/code and ready-list memories.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
    if (dc_we) begin
      dc_mem[dc_waddr] <= dc_wdata;
    end
    dc_q <= dc_mem[idx];
    if (rdy_we) begin
      rdy_mem[rdy_waddr] <= rdy_wdata;
    end
    rdy_q <= rdy_mem[idx[SYM_W-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_BUILD:  state_next = S_COLLECT;
            CMD_QUERY:  state_next = tree_built ? S_QUERY : S_IDLE;
            CMD_DECODE: state_next = tree_built ? S_DEC1 : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_COLLECT: begin
        if (idx[NODE_W-1] && !pend) begin
          if (nodes == '0) begin
            state_next = S_IDLE;
          end else if (nodes == NODE_W'(1)) begin
            state_next = S_ROOT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!scan_more && !pend) begin
          state_next = S_MERGE1;
        end
      end
      S_MERGE1: begin
        if (merge2) begin
          state_next = S_MERGE2;
        end else begin
          state_next = (nready > LEAF_W'(2)) ? S_SCAN : S_ROOT;
        end
      end
      S_MERGE2:    state_next = (nready > LEAF_W'(1)) ? S_SCAN : S_ROOT;
      S_ROOT:      state_next = (LEAF_W'(nodes) > leaves) ? S_ASSIGN_RD : S_LEAF;
      S_ASSIGN_RD: state_next = S_ASSIGN_WL;
      S_ASSIGN_WL: state_next = S_ASSIGN_WR;
      S_ASSIGN_WR: state_next = (LEAF_W'(idx) == leaves) ? S_LEAF : S_ASSIGN_RD;
      S_LEAF: begin
        if (!leaf_more && !pend) begin
          state_next = S_IDLE;
        end
      end
      S_QUERY: state_next = S_IDLE;
      S_DEC1: begin
        if (LEAF_W'(walk) >= leaves && LEAF_W'(child) < leaves) begin
          state_next = S_DEC2;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DEC2:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = nodes;
    node_wdata = '0;
    node_raddr = idx;
    dc_we      = 1'b0;
    dc_waddr   = a_r;
    dc_wdata   = '0;
    rdy_we     = 1'b0;
    rdy_waddr  = pos1;
    rdy_wdata  = new_key;
    cnt_wr     = '{en: 1'b0, addr: symbol, data: frequency};
    code_wr    = '{en: 1'b0, addr: pend_pos, data: '0};
    res        = '{valid: 1'b0, status: STAT_OK, default: '0};
    case (state)
      S_IDLE: begin
        node_raddr = walk;
        if (accept) begin
          case (cmd)
            CMD_LOAD: begin
              cnt_wr.en = 1'b1;
              res.valid = 1'b1;
            end
            CMD_QUERY, CMD_DECODE: begin
              if (!tree_built) begin
                res.valid  = 1'b1;
                res.status = STAT_NO_TREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_COLLECT: begin
        if (pend) begin
          // Every symbol's code entry starts absent; leaves overwrite theirs.
          code_wr.en = 1'b1;
          if (cnt_q != '0) begin
            node_we    = 1'b1;
            node_wdata = LINK_W'(pend_pos);
            rdy_we     = 1'b1;
            rdy_waddr  = SYM_W'(nodes);
            rdy_wdata  = '{weight: WEIGHT_W'(cnt_q),
                           label:  pend_pos ^ LABEL_BIAS,
                           node:   nodes};
          end
        end
        if (idx[NODE_W-1] && !pend && nodes == '0) begin
          res.valid  = 1'b1;
          res.status = STAT_EMPTY;
        end
      end
      S_MERGE1: begin
        node_we    = 1'b1;
        node_wdata = {best1.node, best2.node};
        rdy_we     = 1'b1;
        rdy_waddr  = (last_pos == pos1) ? pos2 : pos1;
      end
      S_MERGE2: begin
        // Move the last ready entry into the second freed slot.
        rdy_we    = 1'b1;
        rdy_waddr = pos2;
        rdy_wdata = last_key;
      end
      S_ROOT: begin
        dc_we    = 1'b1;
        dc_waddr = nodes - NODE_W'(1);
      end
      S_ASSIGN_WL: begin
        dc_we    = 1'b1;
        dc_waddr = node_q[LINK_W-1:NODE_W];
        dc_wdata = '{depth: dc_q.depth + DEPTH_W'(1), code: {dc_q.code[CODE_W-2:0], 1'b0}};
      end
      S_ASSIGN_WR: begin
        dc_we    = 1'b1;
        dc_waddr = a_r;
        dc_wdata = '{depth: a_d + DEPTH_W'(1), code: {a_code[CODE_W-2:0], 1'b1}};
      end
      S_LEAF: begin
        if (pend) begin
          code_wr.en   = 1'b1;
          code_wr.addr = node_q[SYM_W-1:0];
          code_wr.data = '{present: 1'b1, len: dc_q.depth[LEN_W-1:0], code: dc_q.code};
        end
        if (!leaf_more && !pend) begin
          res.valid  = 1'b1;
          res.status = err ? STAT_TOO_LONG : STAT_OK;
          res.leaves = leaves;
        end
      end
      S_QUERY: begin
        res.valid   = 1'b1;
        res.present = code_q.present;
        res.len     = code_q.len;
        res.code    = code_q.code;
      end
      S_DEC1: begin
        node_raddr = child;
        if (LEAF_W'(walk) < leaves) begin
          res.valid  = 1'b1;
          res.dsym   = node_q[SYM_W-1:0];
          res.dvalid = 1'b1;
        end else if (LEAF_W'(child) >= leaves) begin
          res.valid = 1'b1;
        end
      end
      S_DEC2: begin
        res.valid  = 1'b1;
        res.dsym   = node_q[SYM_W-1:0];
        res.dvalid = 1'b1;
      end
      default: ;
    endcase
    if (state == S_COLLECT || state == S_LEAF) begin
      // Leaf count is reported on every build outcome.
      res.leaves = (state == S_COLLECT) ? LEAF_W'(nodes) : leaves;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tree_built   <= 1'b0;
      walk         <= '0;
      root         <= '0;
      leaves       <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res.valid;
      case (state)
        S_IDLE: begin
          if (accept) begin
            bit_r <= code_bit;
            if (cmd == CMD_LOAD || cmd == CMD_BUILD) begin
              tree_built <= 1'b0;
            end
            idx   <= '0;
            pend  <= 1'b0;
            nodes <= '0;
          end
        end
        S_COLLECT: begin
          if (!idx[NODE_W-1]) begin
            idx <= idx + NODE_W'(1);
          end
          pend     <= !idx[NODE_W-1];
          pend_pos <= idx[SYM_W-1:0];
          if (pend && cnt_q != '0) begin
            nodes <= nodes + NODE_W'(1);
          end
          if (idx[NODE_W-1] && !pend) begin
            leaves <= LEAF_W'(nodes);
            nready <= LEAF_W'(nodes);
            idx    <= '0;
            have1  <= 1'b0;
            have2  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            idx <= idx + NODE_W'(1);
          end
          pend     <= scan_more;
          pend_pos <= idx[SYM_W-1:0];
          if (pend) begin
            if (pend_pos == last_pos) begin
              last_key <= rdy_q;
            end
            if (!have1 || key_less(rdy_q, best1)) begin
              best2 <= best1;
              pos2  <= pos1;
              have2 <= have1;
              best1 <= rdy_q;
              pos1  <= pend_pos;
              have1 <= 1'b1;
            end else if (!have2 || key_less(rdy_q, best2)) begin
              best2 <= rdy_q;
              pos2  <= pend_pos;
              have2 <= 1'b1;
            end
          end
        end
        S_MERGE1: begin
          nodes  <= nodes + NODE_W'(1);
          nready <= nready - LEAF_W'(1);
          idx    <= '0;
          pend   <= 1'b0;
          have1  <= 1'b0;
          have2  <= 1'b0;
        end
        S_ROOT: begin
          root <= nodes - NODE_W'(1);
          idx  <= (LEAF_W'(nodes) > leaves) ? nodes - NODE_W'(1) : '0;
          pend <= 1'b0;
          err  <= 1'b0;
        end
        S_ASSIGN_WL: begin
          a_r    <= node_q[NODE_W-1:0];
          a_d    <= dc_q.depth;
          a_code <= dc_q.code;
        end
        S_ASSIGN_WR: begin
          if (LEAF_W'(idx) == leaves) begin
            idx <= '0;
          end else begin
            idx <= idx - NODE_W'(1);
          end
        end
        S_LEAF: begin
          if (leaf_more) begin
            idx <= idx + NODE_W'(1);
          end
          pend <= leaf_more;
          if (pend && dc_q.depth > MAX_CODE_LEN) begin
            err <= 1'b1;
          end
          if (!leaf_more && !pend && !err) begin
            tree_built <= 1'b1;
            walk       <= root;
          end
        end
        S_DEC1: begin
          if (LEAF_W'(walk) < leaves) begin
            walk <= root;
          end else if (LEAF_W'(child) >= leaves) begin
            walk <= child;
          end
        end
        S_DEC2: begin
          walk <= root;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status         <= res.status;
      code_value     <= res.code;
      code_length    <= res.len;
      symbol_present <= res.present;
      decoded_symbol <= res.dsym;
      decoded_valid  <= res.dvalid;
      leaf_count     <= res.leaves;
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code table engine testbench
// Drives load, build, query and decode requests with random gaps, predicts
// every result with an independent Huffman tree model and checks each result
// against the oldest pending prediction in order.
// ----------------------------------------------------------------------------
module testbench;
  import hcte_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              present;
    logic [SYM_W-1:0]  dsym;
    logic              dvalid;
    logic [LEAF_W-1:0] leaves;
  } outcome_t;

  class result_board;
    outcome_t pending[$];
    int       errors;

    function void note(outcome_t e);
      pending.push_back(e);
    endfunction

    function void check(outcome_t got);
      outcome_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.code !== e.code || got.len !== e.len ||
          got.present !== e.present || got.dsym !== e.dsym ||
          got.dvalid !== e.dvalid || got.leaves !== e.leaves) begin
        $display("%0t: mismatch expected st=%0d code=%h len=%0d pr=%0b ds=%0d dv=%0b lc=%0d",
                 $time, e.status, e.code, e.len, e.present, e.dsym, e.dvalid, e.leaves);
        $display("%0t:          actual   st=%0d code=%h len=%0d pr=%0b ds=%0d dv=%0b lc=%0d",
                 $time, got.status, got.code, got.len, got.present, got.dsym, got.dvalid,
                 got.leaves);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command = CMD_LOAD;
  logic [SYM_W-1:0]   symbol = '0;
  logic [COUNT_W-1:0] frequency = '0;
  logic               code_bit = 1'b0;
  logic               result_valid;
  logic [1:0]         status;
  logic [CODE_W-1:0]  code_value;
  logic [LEN_W-1:0]   code_length;
  logic               symbol_present;
  logic [SYM_W-1:0]   decoded_symbol;
  logic               decoded_valid;
  logic [LEAF_W-1:0]  leaf_count;

  huffman_code_table_engine_unit u_top (.*);

  always #5 clk = ~clk;

  result_board board = new();

  // Tree model state.
  logic [COUNT_W-1:0] counts[NUM_SYMBOLS];
  longint             wt[512];
  int                 lab[512];
  int                 kid_l[512], kid_r[512], leaf_sym[512], dep[512];
  logic [63:0]        path[512];
  int                 ready_q[512];
  int                 n_ready, leaf_total, root, walk;
  logic [63:0]        sym_code[NUM_SYMBOLS];
  int                 sym_len[NUM_SYMBOLS];
  bit                 sym_has[NUM_SYMBOLS];
  bit                 built;
  int                 items;

  function automatic bit goes_first(int a, int b);
    if (wt[a] != wt[b]) return wt[a] < wt[b];
    if (lab[a] != lab[b]) return lab[a] < lab[b];
    return a < b;
  endfunction

  function automatic int pop_lowest();
    int best;
    int nd;
    best = 0;
    for (int k = 1; k < n_ready; k++)
      if (goes_first(ready_q[k], ready_q[best])) best = k;
    nd = ready_q[best];
    ready_q[best] = ready_q[n_ready-1];
    n_ready--;
    return nd;
  endfunction

  function automatic logic [1:0] build_codes();
    int nodes;
    int l, r;
    nodes = 0;
    n_ready = 0;
    built = 0;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      sym_code[s] = '0;
      sym_len[s] = 0;
      sym_has[s] = 0;
      if (counts[s] != 0) begin
        wt[nodes] = longint'(counts[s]);
        lab[nodes] = (s >= 128) ? s - 256 : s;
        leaf_sym[nodes] = s;
        ready_q[n_ready++] = nodes;
        nodes++;
      end
    end
    leaf_total = nodes;
    if (nodes == 0) return STAT_EMPTY;
    while (n_ready > 1) begin
      l = pop_lowest();
      r = pop_lowest();
      wt[nodes] = wt[l] + wt[r];
      lab[nodes] = 36;
      leaf_sym[nodes] = 0;
      kid_l[nodes] = l;
      kid_r[nodes] = r;
      ready_q[n_ready++] = nodes;
      nodes++;
    end
    root = ready_q[0];
    dep[root] = 0;
    path[root] = '0;
    // Parents always sit above their children, so a downward sweep suffices.
    for (int i = root; i >= leaf_total; i--) begin
      dep[kid_l[i]] = dep[i] + 1;
      dep[kid_r[i]] = dep[i] + 1;
      path[kid_l[i]] = path[i] << 1;
      path[kid_r[i]] = (path[i] << 1) | 64'd1;
    end
    for (int i = 0; i < leaf_total; i++)
      if (dep[i] > 48) return STAT_TOO_LONG;
    for (int i = 0; i < leaf_total; i++) begin
      sym_code[leaf_sym[i]] = path[i];
      sym_len[leaf_sym[i]] = dep[i];
      sym_has[leaf_sym[i]] = 1;
    end
    walk = root;
    built = 1;
    return STAT_OK;
  endfunction

  function automatic outcome_t predict_result(logic [1:0] cmd, int sym,
                                              logic [COUNT_W-1:0] freq, logic b);
    outcome_t e;
    int nd;
    e = '0;
    if (cmd == CMD_LOAD) begin
      counts[sym] = freq;
      built = 0;
    end else if (cmd == CMD_BUILD) begin
      e.status = build_codes();
      e.leaves = LEAF_W'(leaf_total);
    end else if (!built) begin
      e.status = STAT_NO_TREE;
    end else if (cmd == CMD_QUERY) begin
      if (sym_has[sym]) begin
        e.code = sym_code[sym][CODE_W-1:0];
        e.len = LEN_W'(sym_len[sym]);
        e.present = 1'b1;
      end
    end else begin
      nd = walk;
      if (nd >= leaf_total) nd = b ? kid_r[nd] : kid_l[nd];
      if (nd < leaf_total) begin
        e.dsym = SYM_W'(leaf_sym[nd]);
        e.dvalid = 1'b1;
        walk = root;
      end else begin
        walk = nd;
      end
    end
    return e;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid)
      board.check({status, code_value, code_length, symbol_present, decoded_symbol,
                   decoded_valid, leaf_count});
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(logic [1:0] cmd, int sym, logic [COUNT_W-1:0] freq, logic b);
    int  gap;
    bit  taken;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    symbol = SYM_W'(sym);
    frequency = freq;
    code_bit = b;
    start = 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
    end while (!taken);
    board.note(predict_result(cmd, sym, freq, b));
    items++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 3))
      0: return COUNT_W'($urandom_range(1, 4));
      1: return COUNT_W'($urandom_range(1, 64));
      2: return COUNT_W'($urandom_range(1, 16'hFFFF));
      default: return COUNT_W'($urandom()) | COUNT_W'(1);
    endcase
  endfunction

  int active[$];

  task automatic run_phase(int n);
    int s, k;
    while (active.size() != 0) issue(CMD_LOAD, active.pop_front(), 24'd0, 1'b0);
    for (int i = 0; i < n; i++) begin
      s = (n == NUM_SYMBOLS) ? i : $urandom_range(0, 255);
      if (counts[s] == 0) active.push_back(s);
      issue(CMD_LOAD, s, pick_count(), 1'b0);
    end
    issue(CMD_BUILD, $urandom_range(0, 255), COUNT_W'($urandom()),
          1'($urandom_range(0, 1)));
    k = $urandom_range(15, 40);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 19))
        0: issue(CMD_LOAD, $urandom_range(0, 255), 24'd0, 1'b0);
        1: issue(CMD_BUILD, $urandom_range(0, 255), COUNT_W'($urandom()), 1'b0);
        2, 3, 4, 5, 6:
          issue(CMD_QUERY, active.size() ? active[$urandom_range(0, active.size()-1)]
                                         : $urandom_range(0, 255),
                COUNT_W'($urandom()), 1'b0);
        7: issue(CMD_QUERY, $urandom_range(0, 255), COUNT_W'($urandom()),
                 1'($urandom_range(0, 1)));
        default: issue(CMD_DECODE, $urandom_range(0, 255), COUNT_W'($urandom()),
                       1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    for (int s = 0; s < NUM_SYMBOLS; s++) counts[s] = '0;
    built = 0;
    items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // No tree yet, then an empty table.
    issue(CMD_QUERY, 8'd0, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd255, 24'hFFFFFF, 1'b1);
    issue(CMD_BUILD, 8'd0, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b0);
    // A lone leaf gets an empty code and every bit decodes to it.
    issue(CMD_LOAD, 8'd255, 24'hFFFFFF, 1'b0);
    issue(CMD_BUILD, 8'd0, 24'd0, 1'b0);
    issue(CMD_QUERY, 8'd255, 24'd0, 1'b0);
    issue(CMD_QUERY, 8'd0, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b1);
    // Symbol 36 ties with the internal label; signed labels 0, 127, -128.
    issue(CMD_LOAD, 8'd36, 24'd1, 1'b0);
    issue(CMD_QUERY, 8'd36, 24'd0, 1'b0);
    issue(CMD_LOAD, 8'd0, 24'd1, 1'b0);
    issue(CMD_LOAD, 8'd127, 24'd2, 1'b0);
    issue(CMD_LOAD, 8'd128, 24'd2, 1'b0);
    issue(CMD_LOAD, 8'd255, 24'd1, 1'b0);
    issue(CMD_BUILD, 8'd0, 24'd0, 1'b0);
    issue(CMD_QUERY, 8'd36, 24'd0, 1'b0);
    issue(CMD_QUERY, 8'd128, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b0);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b1);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b1);
    issue(CMD_DECODE, 8'd0, 24'd0, 1'b1);
    drain();
    active = '{0, 36, 127, 128, 255};

    run_phase(NUM_SYMBOLS);
    drain();
    while (items < 1950) begin
      if ($urandom_range(0, 9) == 0) run_phase($urandom_range(17, 60));
      else run_phase($urandom_range(1, 16));
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("huffman_code_table_engine_unit verification clean");
    else
      $display("huffman_code_table_engine_unit verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("huffman_code_table_engine_unit verification failed");
    $finish;
  end

endmodule
